FILE: sv/rlcc_pkg.sv
// Package for the RGB LED color cycle controller.
// Holds the shared types, code constants and per-tick update functions.
// Depends on nothing.
`default_nettype none

package rlcc_pkg;

    // Phase codes: 0 is channel selection in manual mode
    localparam logic [1:0] PH_SELECT = 2'd0;
    localparam logic [1:0] PH_RED    = 2'd1;
    localparam logic [1:0] PH_BLUE   = 2'd2;
    localparam logic [1:0] PH_GREEN  = 2'd3;

    // Press detector codes (code 3 behaves as idle)
    localparam logic [1:0] DET_IDLE  = 2'd0;
    localparam logic [1:0] DET_ARMED = 2'd1;
    localparam logic [1:0] DET_HELD  = 2'd2;

    // Level and rate limits
    localparam logic [7:0] LEVEL_MAX  = 8'd250;
    localparam logic [7:0] LEVEL_MIN  = 8'd10;
    localparam logic [7:0] LEVEL_STEP = 8'd10;
    localparam logic [7:0] RATE_MAX   = 8'd200;
    localparam logic [7:0] RATE_MIN   = 8'd100;
    localparam logic [7:0] RATE_STEP  = 8'd5;

    // Reset values
    localparam logic [15:0] PERIOD_RESET = 16'd11362;
    localparam logic [7:0]  RATE_RESET   = 8'd150;

    // Width scaling: floor(p / 1000) = floor((p >> 3) * RECIP_125 >> RECIP_SHIFT)
    // exact for p below 2**24
    localparam int          RECIP_SHIFT = 28;
    localparam logic [21:0] RECIP_125   = 22'd2147484;
    localparam logic [13:0] WIDTH_MAX   = 14'd16383;

    // State snapshot handed from the control unit to the width path
    typedef struct packed {
        logic       manual;
        logic [1:0] phase;
        logic [7:0] red;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] rate;
    } color_state_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] st;
    } det_result_t;

    typedef struct packed {
        logic [7:0] fall;
        logic [7:0] rise;
        logic       wrap;
    } seg_result_t;

    // Press detector: idle -> armed -> held, press reported on armed -> held
    function automatic det_result_t det_step(input logic [1:0] st, input logic pressed);
        det_result_t r;
        r.hit = 1'b0;
        r.st  = DET_IDLE;
        if (pressed) begin
            case (st)
                DET_ARMED:
                begin
                    r.st  = DET_HELD;
                    r.hit = 1'b1;
                end
                DET_HELD:  r.st = DET_HELD;
                default:   r.st = DET_ARMED;
            endcase
        end
        return r;
    endfunction

    // One ramp step of a segment; rate in hundredths
    function automatic seg_result_t seg_step(input logic [7:0] fall, input logic [7:0] rise,
                                             input logic [7:0] rate);
        seg_result_t r;
        logic [1:0]  up;
        logic [1:0]  dn;
        // integer part of the rate
        up = (rate >= 8'd200) ? 2'd2 : ((rate >= 8'd100) ? 2'd1 : 2'd0);
        // ceiling of the rate
        if (rate == 8'd0)        dn = 2'd0;
        else if (rate <= 8'd100) dn = 2'd1;
        else if (rate <= 8'd200) dn = 2'd2;
        else                     dn = 2'd3;
        r.rise = rise + {6'd0, up};
        r.fall = (fall < {6'd0, dn}) ? 8'd0 : fall - {6'd0, dn};
        r.wrap = (r.rise > LEVEL_MAX) || (r.fall < LEVEL_MIN);
        if (r.wrap) begin
            r.rise = LEVEL_MAX;
            r.fall = LEVEL_MIN;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/rgb_led_color_cycle_controller.sv
// Top level of the RGB LED color cycle controller: stream ports, period
// register, control unit, three width paths and the result register.
// Depends on rlcc_pkg, rlcc_ctrl and rlcc_width.
//
//  Channel  | Direction | Handshake              | Payload
//  ---------+-----------+------------------------+-----------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | switch levels, one tick
//  m_axis   | out       | m_axis_tvalid/tready   | widths, mode, phase
//  cfg      | in        | cfg_valid/cfg_ready    | pwm_period
//
// One tick is taken per cycle while no result waits; its result passes through
// the state register, the product register and the result register.
// The rate is set by the state update; the width path is a product stage
// and a divide-and-saturate stage whose register is the result.
// Reset (rst_n low) restores the levels, rate, mode and a period of 11362.
// A stalled result holds the whole pipeline, so s_axis_tready follows
// m_axis_tready whenever a result is waiting.
`default_nettype none

module rgb_led_color_cycle_controller #(
    parameter int LONG_HOLD_TICKS = 200
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [0] sw1_level, [1] sw2_level, [7:2] zero
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [13:0] red_width, [27:14] blue_width,
                                        // [41:28] green_width, [42] is_manual,
                                        // [44:43] phase_now, [47:45] zero
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [15:0] cfg_data        // pwm_period
);
    import rlcc_pkg::*;

    logic         adv;
    logic         accept;
    color_state_t state;
    logic [15:0]  period_reg;
    logic         st_valid_reg;
    logic         prod_valid_reg;
    logic         out_valid_reg;
    logic         prod_manual_reg;
    logic [1:0]   prod_phase_reg;
    logic         out_manual_reg;
    logic [1:0]   out_phase_reg;
    logic [13:0]  red_w;
    logic [13:0]  blue_w;
    logic [13:0]  green_w;

    // Pipeline advances unless a result waits
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign accept        = s_axis_tvalid && adv;
    assign cfg_ready     = 1'b1;

    // Period register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            period_reg <= cfg_data;
        end
    end

    rlcc_ctrl #(
        .LONG_HOLD_TICKS (LONG_HOLD_TICKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .sw1_level (s_axis_tdata[0]),
        .sw2_level (s_axis_tdata[1]),
        .state     (state)
    );

    rlcc_width u_red (
        .clk    (clk),
        .en     (adv),
        .level  (state.red),
        .period (period_reg),
        .width  (red_w)
    );

    rlcc_width u_blue (
        .clk    (clk),
        .en     (adv),
        .level  (state.blue),
        .period (period_reg),
        .width  (blue_w)
    );

    rlcc_width u_green (
        .clk    (clk),
        .en     (adv),
        .level  (state.green),
        .period (period_reg),
        .width  (green_w)
    );

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            st_valid_reg   <= accept;
            prod_valid_reg <= st_valid_reg;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    // Mode and phase ride alongside the width path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_manual_reg <= state.manual;
            prod_phase_reg  <= state.phase;
            out_manual_reg  <= prod_manual_reg;
            out_phase_reg   <= prod_phase_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'd0, out_phase_reg, out_manual_reg, green_w, blue_w, red_w};

`ifndef SYNTHESIS
    // Manual mode is left only by reset
    a_manual_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(state.manual))
        else $error("manual mode left without reset");

    // Rate stays inside its clamp range
    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state.rate >= RATE_MIN) && (state.rate <= RATE_MAX))
        else $error("rate outside 100..200");

    // Auto mode never reports the selection phase
    a_auto_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[42]) |-> (m_axis_tdata[44:43] != PH_SELECT))
        else $error("auto mode result with selection phase");

    // A tick accepted now updates the state seen on the next cycle
    a_accept_flow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> st_valid_reg)
        else $error("accepted tick lost in pipeline");
`endif

endmodule

`default_nettype wire

FILE: sv/rlcc_ctrl.sv
// Control unit of the RGB LED color cycle controller: mode, phase, levels,
// rate, press detectors and hold counter, updated once per accepted tick.
// Depends on rlcc_pkg.
`default_nettype none

module rlcc_ctrl #(
    parameter int LONG_HOLD_TICKS = 200
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   accept,
    input  wire                   sw1_level,
    input  wire                   sw2_level,
    output rlcc_pkg::color_state_t state
);
    import rlcc_pkg::*;

    localparam int HW = $clog2(LONG_HOLD_TICKS + 2);

    logic          manual_reg, manual_next;
    logic [1:0]    phase_reg, phase_next;
    logic [7:0]    red_reg, red_next;
    logic [7:0]    blue_reg, blue_next;
    logic [7:0]    green_reg, green_next;
    logic [7:0]    rate_reg, rate_next;
    logic [1:0]    det1_reg, det1_next;
    logic [1:0]    det2_reg, det2_next;
    logic [HW-1:0] hold_reg, hold_next;

    // Next state for one tick
    always_comb
    begin
        logic        p1;
        logic        p2;
        det_result_t d1;
        det_result_t d2;
        seg_result_t sg;
        logic [8:0]  sum;
        logic [7:0]  lvl;

        p1 = ~sw1_level;
        p2 = ~sw2_level;

        manual_next = manual_reg;
        phase_next  = phase_reg;
        red_next    = red_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        rate_next   = rate_reg;
        det1_next   = det1_reg;
        det2_next   = det2_reg;
        hold_next   = hold_reg;
        d1          = det_step(det1_reg, p1);
        d2          = det_step(det2_reg, p2);
        sg          = '0;
        sum         = '0;
        lvl         = '0;

        // both switches pressed: enter manual selection
        if (p1 && p2) begin
            manual_next = 1'b1;
            phase_next  = PH_SELECT;
        end

        if (!manual_next) begin
            // auto mode: rate adjust, then one ramp step
            det1_next = d1.st;
            det2_next = d2.st;
            if (d1.hit) begin
                sum       = {1'b0, rate_next} + {1'b0, RATE_STEP};
                rate_next = (sum > {1'b0, RATE_MAX}) ? RATE_MAX : sum[7:0];
            end
            if (d2.hit) begin
                rate_next = (rate_next < RATE_MIN + RATE_STEP) ? RATE_MIN
                                                               : rate_next - RATE_STEP;
            end
            unique case (phase_next)
                PH_RED:
                begin
                    sg        = seg_step(red_reg, blue_reg, rate_next);
                    red_next  = sg.fall;
                    blue_next = sg.rise;
                    if (sg.wrap) phase_next = PH_BLUE;
                end
                PH_BLUE:
                begin
                    sg         = seg_step(blue_reg, green_reg, rate_next);
                    blue_next  = sg.fall;
                    green_next = sg.rise;
                    if (sg.wrap) phase_next = PH_GREEN;
                end
                PH_GREEN:
                begin
                    sg         = seg_step(green_reg, red_reg, rate_next);
                    green_next = sg.fall;
                    red_next   = sg.rise;
                    if (sg.wrap) phase_next = PH_RED;
                end
                default: ;
            endcase
        end else if (phase_next == PH_SELECT) begin
            // channel selection by hold length
            if (p2) begin
                if (p1 && hold_reg <= HW'(LONG_HOLD_TICKS)) hold_next = hold_reg + HW'(1);
            end else begin
                if (hold_reg > HW'(LONG_HOLD_TICKS)) phase_next = PH_GREEN;
                else if (hold_reg == HW'(1))         phase_next = PH_RED;
                else if (hold_reg >= HW'(2))         phase_next = PH_BLUE;
                hold_next = '0;
            end
        end else begin
            // manual step of the chosen channel
            det1_next = d1.st;
            det2_next = d2.st;
            unique case (phase_next)
                PH_RED:   lvl = red_reg;
                PH_BLUE:  lvl = blue_reg;
                default:  lvl = green_reg;
            endcase
            if (d1.hit) begin
                sum = {1'b0, lvl} + {1'b0, LEVEL_STEP};
                lvl = (sum > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : sum[7:0];
            end
            if (d2.hit) begin
                lvl = (lvl < LEVEL_MIN + LEVEL_STEP) ? LEVEL_MIN : lvl - LEVEL_STEP;
            end
            unique case (phase_next)
                PH_RED:   red_next   = lvl;
                PH_BLUE:  blue_next  = lvl;
                default:  green_next = lvl;
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            manual_reg <= 1'b0;
            phase_reg  <= PH_RED;
            red_reg    <= LEVEL_MAX;
            blue_reg   <= LEVEL_MIN;
            green_reg  <= LEVEL_MIN;
            rate_reg   <= RATE_RESET;
            det1_reg   <= DET_IDLE;
            det2_reg   <= DET_IDLE;
            hold_reg   <= '0;
        end else if (accept) begin
            manual_reg <= manual_next;
            phase_reg  <= phase_next;
            red_reg    <= red_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            rate_reg   <= rate_next;
            det1_reg   <= det1_next;
            det2_reg   <= det2_next;
            hold_reg   <= hold_next;
        end
    end

    assign state.manual = manual_reg;
    assign state.phase  = phase_reg;
    assign state.red    = red_reg;
    assign state.blue   = blue_reg;
    assign state.green  = green_reg;
    assign state.rate   = rate_reg;

endmodule

`default_nettype wire

FILE: sv/rlcc_width.sv
// PWM width path for one color channel: level * period, then / 1000 by
// reciprocal multiply, saturated to 14 bits. Two register stages.
// Depends on rlcc_pkg.
`default_nettype none

module rlcc_width (
    input  wire         clk,
    input  wire         en,
    input  wire  [7:0]  level,
    input  wire  [15:0] period,
    output logic [13:0] width
);
    import rlcc_pkg::*;

    logic [23:0] prod_reg, prod_next;
    logic [13:0] width_reg, width_next;
    logic [42:0] scaled;
    logic [14:0] quot;

    // Stage one: level times period
    assign prod_next = {16'd0, level} * {8'd0, period};

    // Stage two: divide by 1000 and saturate
    assign scaled     = {22'd0, prod_reg[23:3]} * {21'd0, RECIP_125};
    assign quot       = scaled[42:RECIP_SHIFT];
    assign width_next = (quot > {1'b0, WIDTH_MAX}) ? WIDTH_MAX : quot[13:0];

    always_ff @(posedge clk)
    begin
        if (en) begin
            prod_reg  <= prod_next;
            width_reg <= width_next;
        end
    end

    assign width = width_reg;

endmodule

`default_nettype wire
